// File: src/fts_pkg.sv
// ----------------------------------------------------------------------------
// fts_pkg
// Types, constants and codes shared by the thread scheduler modules.
// ----------------------------------------------------------------------------
package fts_pkg;

  localparam int THREADS     = 16;
  localparam int WAIT_QUEUES = 32;
  localparam int TID_W       = $clog2(THREADS);
  localparam int QID_W       = $clog2(WAIT_QUEUES);
  localparam int CNT_W       = $clog2(THREADS + 1);

  typedef logic [TID_W-1:0] tid_t;
  typedef logic [QID_W-1:0] qid_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    TS_FREE     = 3'd0,
    TS_RUNNING  = 3'd1,
    TS_READY    = 3'd2,
    TS_BLOCKED  = 3'd3,
    TS_KREADY   = 3'd4,
    TS_KBLOCKED = 3'd5
  } thread_st_t;

  typedef enum logic [2:0] {
    CMD_CREATE   = 3'd0,
    CMD_YIELD    = 3'd1,
    CMD_EXIT     = 3'd2,
    CMD_KILL     = 3'd3,
    CMD_SLEEP    = 3'd4,
    CMD_WAKE_ONE = 3'd5,
    CMD_WAKE_ALL = 3'd6,
    CMD_JOIN     = 3'd7
  } cmd_t;

  localparam logic [1:0] KIND_NAMED = 2'd0;
  localparam logic [1:0] KIND_ANY   = 2'd1;
  localparam logic [1:0] KIND_SELF  = 2'd2;

  typedef enum logic [2:0] {
    SS_OK         = 3'd0,
    SS_INVALID    = 3'd1,
    SS_NONE_READY = 3'd2,
    SS_NO_ID      = 3'd3,
    SS_LAST_EXIT  = 3'd4
  } sched_status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_TGT_RD, S_TGT_CHK, S_CR_RD, S_CR_CHK, S_RM_RD, S_RM_CHK,
    S_YN_PUSH, S_YN_RUN, S_DSP_RD, S_DSP_CHK, S_WQ_RD, S_WQ_CHK, S_WQ_UPD,
    S_DR_RD, S_DR_CHK, S_DR_NEXTQ, S_DR_QCHK, S_SQ_RD, S_SQ_UPD, S_DONE
  } state_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [1:0] kind;
    tid_t       tgt;
    qid_t       qidx;
  } cmd_item_t;

  typedef struct packed {
    sched_status_t status;
    tid_t          result_thread;
    tid_t          running_thread;
    cnt_t          woken_count;
  } result_t;

  typedef struct packed {
    tid_t head;
    tid_t tail;
    cnt_t count;
  } q_entry_t;

  typedef struct packed {
    tid_t       rd_addr;
    logic       st_we;
    tid_t       st_addr;
    thread_st_t st_data;
    logic       lk_we;
    tid_t       lk_addr;
    tid_t       lk_data;
  } tm_req_t;

  typedef struct packed {
    thread_st_t st;
    tid_t       link;
  } tm_rd_t;

  typedef struct packed {
    qid_t     rd_addr;
    logic     we;
    qid_t     wr_addr;
    q_entry_t wr_data;
  } qm_req_t;

endpackage

// File: src/fts_thread_mem.sv
// ----------------------------------------------------------------------------
// fts_thread_mem
// Per-thread table: status and next link, one read port with registered data.
// ----------------------------------------------------------------------------
module fts_thread_mem (
  input  logic            clk,
  input  logic            rst_n,
  input  fts_pkg::tm_req_t req,
  output fts_pkg::tm_rd_t  rd
);

  fts_pkg::thread_st_t st_mem [fts_pkg::THREADS];
  fts_pkg::tid_t       lk_mem [fts_pkg::THREADS];
  logic [fts_pkg::THREADS-1:0] st_vld_r;

  fts_pkg::thread_st_t rd_st_r;
  fts_pkg::tid_t       rd_lk_r;
  logic                rd_vld_r;
  logic                rd_zero_r;

  always_ff @(posedge clk) begin
    if (req.st_we) begin
      st_mem[req.st_addr] <= req.st_data;
    end
    if (req.lk_we) begin
      lk_mem[req.lk_addr] <= req.lk_data;
    end
    rd_st_r   <= st_mem[req.rd_addr];
    rd_lk_r   <= lk_mem[req.rd_addr];
    rd_vld_r  <= st_vld_r[req.rd_addr];
    rd_zero_r <= (req.rd_addr == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r <= '0;
    end else if (req.st_we) begin
      st_vld_r[req.st_addr] <= 1'b1;
    end
  end

  // unwritten entries read as reset status: thread 0 running, rest free
  always_comb begin
    rd.link = rd_lk_r;
    if (rd_vld_r) begin
      rd.st = rd_st_r;
    end else if (rd_zero_r) begin
      rd.st = fts_pkg::TS_RUNNING;
    end else begin
      rd.st = fts_pkg::TS_FREE;
    end
  end

endmodule

// File: src/fts_queue_mem.sv
// ----------------------------------------------------------------------------
// fts_queue_mem
// Wait queue descriptors: head, tail and count, registered read.
// ----------------------------------------------------------------------------
module fts_queue_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  fts_pkg::qm_req_t  req,
  output fts_pkg::q_entry_t rd
);

  fts_pkg::q_entry_t mem [fts_pkg::WAIT_QUEUES];
  logic [fts_pkg::WAIT_QUEUES-1:0] vld_r;

  fts_pkg::q_entry_t rd_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_r     <= mem[req.rd_addr];
    rd_vld_r <= vld_r[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.we) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    rd       = rd_r;
    rd.count = rd_vld_r ? rd_r.count : '0;
  end

endmodule

// File: src/fts_ctrl.sv
// ----------------------------------------------------------------------------
// fts_ctrl
// Command sequencer: ready queue registers, list walks, dispatch and wakes.
// ----------------------------------------------------------------------------
module fts_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fts_pkg::cmd_item_t in_item,
  output logic               res_valid,
  input  logic               res_ready,
  output fts_pkg::result_t   res,
  output fts_pkg::tm_req_t   tm,
  input  fts_pkg::tm_rd_t    tm_rd,
  output fts_pkg::qm_req_t   qm,
  input  fts_pkg::q_entry_t  qm_rd
);

  fts_pkg::state_t        state_r, state_nxt;
  fts_pkg::cmd_t          cmd_r, cmd_nxt;
  logic [1:0]             kind_r, kind_nxt;
  fts_pkg::tid_t          tgt_r, tgt_nxt;
  fts_pkg::qid_t          qi_r, qi_nxt;
  fts_pkg::tid_t          cur_r, cur_nxt;
  fts_pkg::tid_t          rhead_r, rhead_nxt;
  fts_pkg::tid_t          rtail_r, rtail_nxt;
  fts_pkg::cnt_t          rcnt_r, rcnt_nxt;
  fts_pkg::cnt_t          moved_r, moved_nxt;
  fts_pkg::sched_status_t stat_r, stat_nxt;
  fts_pkg::tid_t          res_r, res_nxt;
  logic                   res_cur_r, res_cur_nxt;
  fts_pkg::tid_t          idx_r, idx_nxt;
  fts_pkg::tid_t          walk_r, walk_nxt;
  fts_pkg::tid_t          prev_r, prev_nxt;
  logic                   first_r, first_nxt;
  logic                   tkill_r, tkill_nxt;
  fts_pkg::qid_t          wq_r, wq_nxt;
  logic                   all_r, all_nxt;
  logic                   cont_r, cont_nxt;
  fts_pkg::q_entry_t      qe_r, qe_nxt;
  fts_pkg::cnt_t          n_r, n_nxt;
  logic [fts_pkg::THREADS-1:0] pend_r, pend_nxt;
  fts_pkg::qid_t          sq_r, sq_nxt;
  logic                   smode_r, smode_nxt;

  logic          push_en;
  fts_pkg::tid_t push_tid;
  fts_pkg::tid_t low_j;
  logic          succ;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fts_pkg::S_IDLE;
      cur_r   <= '0;
      rhead_r <= '0;
      rtail_r <= '0;
      rcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      rhead_r <= rhead_nxt;
      rtail_r <= rtail_nxt;
      rcnt_r  <= rcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    kind_r    <= kind_nxt;
    tgt_r     <= tgt_nxt;
    qi_r      <= qi_nxt;
    moved_r   <= moved_nxt;
    stat_r    <= stat_nxt;
    res_r     <= res_nxt;
    res_cur_r <= res_cur_nxt;
    idx_r     <= idx_nxt;
    walk_r    <= walk_nxt;
    prev_r    <= prev_nxt;
    first_r   <= first_nxt;
    tkill_r   <= tkill_nxt;
    wq_r      <= wq_nxt;
    all_r     <= all_nxt;
    cont_r    <= cont_nxt;
    qe_r      <= qe_nxt;
    n_r       <= n_nxt;
    pend_r    <= pend_nxt;
    sq_r      <= sq_nxt;
    smode_r   <= smode_nxt;
  end

  always_comb begin
    low_j = '0;
    for (int i = fts_pkg::THREADS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        low_j = fts_pkg::tid_t'(i);
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    kind_nxt    = kind_r;
    tgt_nxt     = tgt_r;
    qi_nxt      = qi_r;
    cur_nxt     = cur_r;
    rhead_nxt   = rhead_r;
    rtail_nxt   = rtail_r;
    rcnt_nxt    = rcnt_r;
    moved_nxt   = moved_r;
    stat_nxt    = stat_r;
    res_nxt     = res_r;
    res_cur_nxt = res_cur_r;
    idx_nxt     = idx_r;
    walk_nxt    = walk_r;
    prev_nxt    = prev_r;
    first_nxt   = first_r;
    tkill_nxt   = tkill_r;
    wq_nxt      = wq_r;
    all_nxt     = all_r;
    cont_nxt    = cont_r;
    qe_nxt      = qe_r;
    n_nxt       = n_r;
    pend_nxt    = pend_r;
    sq_nxt      = sq_r;
    smode_nxt   = smode_r;
    tm          = '0;
    tm.rd_addr  = walk_r;
    qm          = '0;
    qm.rd_addr  = wq_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    push_en     = 1'b0;
    push_tid    = '0;
    succ        = 1'b0;

    unique case (state_r)
      fts_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt     = in_item.cmd;
          kind_nxt    = in_item.kind;
          tgt_nxt     = in_item.tgt;
          qi_nxt      = in_item.qidx;
          moved_nxt   = '0;
          stat_nxt    = fts_pkg::SS_OK;
          res_nxt     = '0;
          res_cur_nxt = 1'b0;
          state_nxt   = fts_pkg::S_TGT_RD;
        end
      end
      fts_pkg::S_TGT_RD: begin
        tm.rd_addr = tgt_r;
        state_nxt  = fts_pkg::S_TGT_CHK;
      end
      fts_pkg::S_TGT_CHK: begin
        state_nxt = fts_pkg::S_DONE;
        walk_nxt  = rhead_r;
        n_nxt     = rcnt_r;
        pend_nxt  = '0;
        unique case (cmd_r) inside
          fts_pkg::CMD_CREATE: begin
            idx_nxt   = '0;
            state_nxt = fts_pkg::S_CR_RD;
          end
          fts_pkg::CMD_YIELD: begin
            if (kind_r == fts_pkg::KIND_SELF ||
                (kind_r == fts_pkg::KIND_NAMED && tgt_r == cur_r)) begin
              res_nxt = cur_r;
            end else if (kind_r == fts_pkg::KIND_ANY) begin
              if (rcnt_r == '0) begin
                stat_nxt = fts_pkg::SS_NONE_READY;
              end else begin
                tm.st_we    = 1'b1;
                tm.st_addr  = cur_r;
                tm.st_data  = fts_pkg::TS_READY;
                push_en     = 1'b1;
                push_tid    = cur_r;
                res_cur_nxt = 1'b1;
                state_nxt   = fts_pkg::S_DSP_RD;
              end
            end else if (kind_r == fts_pkg::KIND_NAMED &&
                         (tm_rd.st == fts_pkg::TS_READY ||
                          tm_rd.st == fts_pkg::TS_KREADY)) begin
              tkill_nxt = (tm_rd.st == fts_pkg::TS_KREADY);
              first_nxt = 1'b1;
              state_nxt = fts_pkg::S_RM_RD;
            end else begin
              stat_nxt = fts_pkg::SS_INVALID;
            end
          end
          fts_pkg::CMD_EXIT: begin
            pend_nxt[cur_r] = 1'b1;
            smode_nxt       = 1'b0;
            state_nxt       = fts_pkg::S_DR_RD;
          end
          fts_pkg::CMD_KILL: begin
            if (tgt_r != cur_r && tm_rd.st != fts_pkg::TS_FREE) begin
              tm.st_addr = tgt_r;
              if (tm_rd.st == fts_pkg::TS_READY) begin
                tm.st_we   = 1'b1;
                tm.st_data = fts_pkg::TS_KREADY;
              end else if (tm_rd.st == fts_pkg::TS_BLOCKED) begin
                tm.st_we   = 1'b1;
                tm.st_data = fts_pkg::TS_KBLOCKED;
              end
              res_nxt = tgt_r;
            end else begin
              stat_nxt = fts_pkg::SS_INVALID;
            end
          end
          fts_pkg::CMD_SLEEP: begin
            smode_nxt = 1'b1;
            sq_nxt    = qi_r;
            state_nxt = fts_pkg::S_DR_RD;
          end
          fts_pkg::CMD_WAKE_ONE, fts_pkg::CMD_WAKE_ALL: begin
            wq_nxt    = qi_r;
            all_nxt   = (cmd_r == fts_pkg::CMD_WAKE_ALL);
            cont_nxt  = 1'b0;
            state_nxt = fts_pkg::S_WQ_RD;
          end
          fts_pkg::CMD_JOIN: begin
            if (tgt_r != cur_r && tm_rd.st != fts_pkg::TS_FREE) begin
              smode_nxt = 1'b1;
              sq_nxt    = fts_pkg::qid_t'(tgt_r);
              state_nxt = fts_pkg::S_DR_RD;
            end else begin
              stat_nxt = fts_pkg::SS_INVALID;
            end
          end
        endcase
      end
      fts_pkg::S_CR_RD: begin
        tm.rd_addr = idx_r;
        state_nxt  = fts_pkg::S_CR_CHK;
      end
      fts_pkg::S_CR_CHK: begin
        if (tm_rd.st == fts_pkg::TS_FREE) begin
          tm.st_we   = 1'b1;
          tm.st_addr = idx_r;
          tm.st_data = fts_pkg::TS_READY;
          push_en    = 1'b1;
          push_tid   = idx_r;
          res_nxt    = idx_r;
          state_nxt  = fts_pkg::S_DONE;
        end else if (idx_r == fts_pkg::tid_t'(fts_pkg::THREADS - 1)) begin
          stat_nxt  = fts_pkg::SS_NO_ID;
          state_nxt = fts_pkg::S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = fts_pkg::S_CR_RD;
        end
      end
      fts_pkg::S_RM_RD: begin
        state_nxt = fts_pkg::S_RM_CHK;
      end
      fts_pkg::S_RM_CHK: begin
        if (walk_r == tgt_r) begin
          if (first_r) begin
            if (rcnt_r > fts_pkg::cnt_t'(1)) begin
              rhead_nxt = tm_rd.link;
            end
          end else if (walk_r == rtail_r) begin
            rtail_nxt = prev_r;
          end else begin
            tm.lk_we   = 1'b1;
            tm.lk_addr = prev_r;
            tm.lk_data = tm_rd.link;
          end
          rcnt_nxt  = rcnt_r - 1'b1;
          state_nxt = fts_pkg::S_YN_PUSH;
        end else begin
          prev_nxt  = walk_r;
          walk_nxt  = tm_rd.link;
          first_nxt = 1'b0;
          state_nxt = fts_pkg::S_RM_RD;
        end
      end
      fts_pkg::S_YN_PUSH: begin
        tm.st_we   = 1'b1;
        tm.st_addr = cur_r;
        tm.st_data = fts_pkg::TS_READY;
        push_en    = 1'b1;
        push_tid   = cur_r;
        state_nxt  = fts_pkg::S_YN_RUN;
      end
      fts_pkg::S_YN_RUN: begin
        res_nxt    = tgt_r;
        tm.st_we   = 1'b1;
        tm.st_addr = tgt_r;
        if (!tkill_r) begin
          tm.st_data = fts_pkg::TS_RUNNING;
          cur_nxt    = tgt_r;
          state_nxt  = fts_pkg::S_DONE;
        end else begin
          tm.st_data = fts_pkg::TS_FREE;
          wq_nxt     = fts_pkg::qid_t'(tgt_r);
          all_nxt    = 1'b1;
          cont_nxt   = 1'b1;
          state_nxt  = fts_pkg::S_WQ_RD;
        end
      end
      fts_pkg::S_DSP_RD: begin
        tm.rd_addr = rhead_r;
        state_nxt  = (rcnt_r == '0) ? fts_pkg::S_DONE : fts_pkg::S_DSP_CHK;
      end
      fts_pkg::S_DSP_CHK: begin
        if (rcnt_r > fts_pkg::cnt_t'(1)) begin
          rhead_nxt = tm_rd.link;
        end
        rcnt_nxt   = rcnt_r - 1'b1;
        tm.st_we   = 1'b1;
        tm.st_addr = rhead_r;
        if (tm_rd.st == fts_pkg::TS_KREADY) begin
          tm.st_data = fts_pkg::TS_FREE;
          wq_nxt     = fts_pkg::qid_t'(rhead_r);
          all_nxt    = 1'b1;
          cont_nxt   = 1'b1;
          state_nxt  = fts_pkg::S_WQ_RD;
        end else begin
          tm.st_data = fts_pkg::TS_RUNNING;
          cur_nxt    = rhead_r;
          state_nxt  = fts_pkg::S_DONE;
        end
      end
      fts_pkg::S_WQ_RD: begin
        state_nxt = fts_pkg::S_WQ_CHK;
      end
      fts_pkg::S_WQ_CHK: begin
        tm.rd_addr = qm_rd.head;
        qe_nxt     = qm_rd;
        if (qm_rd.count == '0) begin
          state_nxt = cont_r ? fts_pkg::S_DSP_RD : fts_pkg::S_DONE;
        end else begin
          state_nxt = fts_pkg::S_WQ_UPD;
        end
      end
      fts_pkg::S_WQ_UPD: begin
        qm.we            = 1'b1;
        qm.wr_addr       = wq_r;
        qm.wr_data       = qe_r;
        qm.wr_data.count = qe_r.count - 1'b1;
        if (qe_r.count > fts_pkg::cnt_t'(1)) begin
          qm.wr_data.head = tm_rd.link;
        end
        tm.st_we   = 1'b1;
        tm.st_addr = qe_r.head;
        tm.st_data = (tm_rd.st == fts_pkg::TS_KBLOCKED) ? fts_pkg::TS_KREADY
                                                        : fts_pkg::TS_READY;
        push_en    = 1'b1;
        push_tid   = qe_r.head;
        moved_nxt  = moved_r + 1'b1;
        if (all_r) begin
          state_nxt = fts_pkg::S_WQ_RD;
        end else begin
          state_nxt = cont_r ? fts_pkg::S_DSP_RD : fts_pkg::S_DONE;
        end
      end
      fts_pkg::S_DR_RD: begin
        state_nxt = (n_r == '0) ? fts_pkg::S_DR_NEXTQ : fts_pkg::S_DR_CHK;
      end
      fts_pkg::S_DR_CHK: begin
        succ = (tm_rd.st == fts_pkg::TS_READY || tm_rd.st == fts_pkg::TS_BLOCKED ||
                (smode_r && fts_pkg::qid_t'(walk_r) == sq_r));
        if (succ) begin
          tm.st_we   = 1'b1;
          tm.st_addr = cur_r;
          if (cmd_r == fts_pkg::CMD_EXIT) begin
            tm.st_data = fts_pkg::TS_FREE;
            wq_nxt     = fts_pkg::qid_t'(cur_r);
            all_nxt    = 1'b1;
            cont_nxt   = 1'b1;
            state_nxt  = fts_pkg::S_WQ_RD;
          end else begin
            tm.st_data = fts_pkg::TS_BLOCKED;
            if (cmd_r == fts_pkg::CMD_JOIN) begin
              res_nxt = tgt_r;
            end
            state_nxt = fts_pkg::S_SQ_RD;
          end
        end else begin
          if (tm_rd.st == fts_pkg::TS_KREADY || tm_rd.st == fts_pkg::TS_KBLOCKED) begin
            pend_nxt[walk_r] = 1'b1;
          end
          n_nxt     = n_r - 1'b1;
          walk_nxt  = tm_rd.link;
          state_nxt = fts_pkg::S_DR_RD;
        end
      end
      fts_pkg::S_DR_NEXTQ: begin
        qm.rd_addr = fts_pkg::qid_t'(low_j);
        if (pend_r == '0) begin
          stat_nxt  = (cmd_r == fts_pkg::CMD_EXIT) ? fts_pkg::SS_LAST_EXIT
                                                   : fts_pkg::SS_NONE_READY;
          state_nxt = fts_pkg::S_DONE;
        end else begin
          pend_nxt[low_j] = 1'b0;
          state_nxt       = fts_pkg::S_DR_QCHK;
        end
      end
      fts_pkg::S_DR_QCHK: begin
        walk_nxt  = qm_rd.head;
        n_nxt     = qm_rd.count;
        state_nxt = fts_pkg::S_DR_RD;
      end
      fts_pkg::S_SQ_RD: begin
        qm.rd_addr = sq_r;
        state_nxt  = fts_pkg::S_SQ_UPD;
      end
      fts_pkg::S_SQ_UPD: begin
        qm.we            = 1'b1;
        qm.wr_addr       = sq_r;
        qm.wr_data       = qm_rd;
        qm.wr_data.tail  = cur_r;
        qm.wr_data.count = qm_rd.count + 1'b1;
        if (qm_rd.count == '0) begin
          qm.wr_data.head = cur_r;
        end else begin
          tm.lk_we   = 1'b1;
          tm.lk_addr = qm_rd.tail;
          tm.lk_data = cur_r;
        end
        state_nxt = fts_pkg::S_DSP_RD;
      end
      fts_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = fts_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fts_pkg::S_IDLE;
      end
    endcase

    if (push_en) begin
      if (rcnt_r == '0) begin
        rhead_nxt = push_tid;
      end else begin
        tm.lk_we   = 1'b1;
        tm.lk_addr = rtail_r;
        tm.lk_data = push_tid;
      end
      rtail_nxt = push_tid;
      rcnt_nxt  = rcnt_r + 1'b1;
    end
  end

  assign res.status         = stat_r;
  assign res.result_thread  = res_cur_r ? cur_r : res_r;
  assign res.running_thread = cur_r;
  assign res.woken_count    = moved_r;

  a_dispatch_sets_cur: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fts_pkg::S_DSP_CHK && tm_rd.st != fts_pkg::TS_KREADY)
      |=> (cur_r == $past(rhead_r)))
    else $error("dispatch did not make the ready head the running thread");

  a_wake_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fts_pkg::S_WQ_UPD) |=> (rcnt_r == $past(rcnt_r) + 1'b1))
    else $error("woken thread not added to ready queue");

  a_ready_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (rcnt_r < fts_pkg::cnt_t'(fts_pkg::THREADS)))
    else $error("ready queue count out of range");

endmodule

// File: src/fifo_thread_scheduler.sv
// ----------------------------------------------------------------------------
// fifo_thread_scheduler
// Hardware thread scheduler with a FIFO ready queue and linked wait queues.
// ----------------------------------------------------------------------------
// One command word in, one result word out. Kill and failed checks are the
// shortest commands; every list element touched costs a read on the single
// read port of the thread table, and create scans that table entry by entry.
// Exit, sleep and join first walk the lists that dispatch could reach to
// confirm a live thread remains, then commit. The result sits in an output
// register so the next command can be taken while it waits. No clearing
// pass after reset.
module fifo_thread_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[2:0], target_kind[4:3], target_thread[8:5], queue_index[13:9]
  input  logic [15:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], result_thread[6:3], running_thread[10:7], woken_count[15:11]
  output logic [15:0] out_tdata
);

  fts_pkg::cmd_item_t item;
  fts_pkg::result_t   res;
  fts_pkg::tm_req_t   tm;
  fts_pkg::tm_rd_t    tm_rd;
  fts_pkg::qm_req_t   qm;
  fts_pkg::q_entry_t  qm_rd;
  logic               res_valid;
  logic               res_ready;
  logic               out_valid_r;
  logic [15:0]        out_data_r;

  assign item.cmd  = fts_pkg::cmd_t'(in_tdata[2:0]);
  assign item.kind = in_tdata[4:3];
  assign item.tgt  = in_tdata[8:5];
  assign item.qidx = in_tdata[13:9];

  fts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .tm        (tm),
    .tm_rd     (tm_rd),
    .qm        (qm),
    .qm_rd     (qm_rd)
  );

  fts_thread_mem u_tmem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tm),
    .rd    (tm_rd)
  );

  fts_queue_mem u_qmem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (qm),
    .rd    (qm_rd)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= {res.woken_count, res.running_thread, res.result_thread, res.status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
